// ===== sv/iss_pkg.sv =====
// Shared constants, types and helpers of the IMU sample scaler.
package iss_pkg;

    localparam int RAW_W      = 16;
    localparam int MAX_BURST  = 128;
    localparam int TALLY_W    = $clog2(MAX_BURST + 1);
    localparam int ACC_W      = RAW_W + $clog2(MAX_BURST);
    localparam int FS_W       = 2;
    localparam int COEF_W     = 24;
    localparam int GAIN_W     = 24;
    localparam int OFFSET_W   = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 24;

    localparam int FRAC_SH    = 14;
    localparam int L_PROD_W   = RAW_W + COEF_W + 1;
    localparam int L_SH_W     = L_PROD_W + (2 ** FS_W - 1);
    localparam int LANE_W     = L_SH_W - FRAC_SH;
    localparam int NUM_LANES  = 6;

    localparam int ACCEL_W    = 25;
    localparam int GYRO_W     = 28;
    localparam int TEMP_W     = 16;
    localparam int SAMP_W     = 8;
    localparam int ACCEL_MAX  = 2 ** (ACCEL_W - 1) - 1;
    localparam int ACCEL_MIN  = -(2 ** (ACCEL_W - 1));
    localparam int TEMP_MAX   = 2 ** (TEMP_W - 1) - 1;
    localparam int TEMP_MIN   = -(2 ** (TEMP_W - 1));
    localparam int SAMP_MAX   = 2 ** SAMP_W - 1;

    localparam int T_PROD_W       = ACC_W + GAIN_W + 1;
    localparam int DIV_STEP_BITS  = 4;
    localparam int DVD_W          = ((T_PROD_W + DIV_STEP_BITS - 1) / DIV_STEP_BITS)
                                    * DIV_STEP_BITS;
    localparam int DIV_ITERS      = DVD_W / DIV_STEP_BITS;
    localparam int DIV_CNT_W      = $clog2(DIV_ITERS);
    localparam int Q_SH           = 16;
    localparam int QSH_W          = DVD_W + 1 - Q_SH;
    localparam int DEG_W          = QSH_W + 1;

    localparam int IN_W       = 7 * RAW_W;
    localparam int TEMP_IN_LSB = 3 * RAW_W;
    localparam int GYRO_IN_LSB = 4 * RAW_W;
    localparam int OUT_BITS   = 3 * ACCEL_W + 3 * GYRO_W + TEMP_W + SAMP_W;
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W  = OUT_W - OUT_BITS;
    localparam int TEMP_OUT_LSB = 3 * ACCEL_W + 3 * GYRO_W;
    localparam int SAMP_OUT_LSB = TEMP_OUT_LSB + TEMP_W;

    localparam logic signed [RAW_W-1:0] RAW_MIN = RAW_W'(-(2 ** (RAW_W - 1)));
    localparam logic signed [RAW_W-1:0] RAW_MAX = RAW_W'(2 ** (RAW_W - 1) - 1);
    localparam logic [COEF_W-1:0] GYRO_COEF   = COEF_W'(500 * (2 ** FRAC_SH));
    localparam logic [COEF_W-1:0] GRAVITY_RST = COEF_W'(642689);
    localparam logic [GAIN_W-1:0] GAIN_RST    = GAIN_W'(51338);
    localparam logic signed [OFFSET_W-1:0] OFFSET_RST = OFFSET_W'(6400);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACCEL_FS    = 3'd0,
        CFG_GYRO_FS     = 3'd1,
        CFG_GRAVITY     = 3'd2,
        CFG_TEMP_GAIN   = 3'd3,
        CFG_TEMP_OFFSET = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCALE,
        ST_MERGE
    } t_state;

    typedef enum logic [2:0] {
        TS_IDLE,
        TS_MUL,
        TS_START,
        TS_DIV,
        TS_NEG,
        TS_ADD,
        TS_DONE
    } t_tstate;

    typedef struct packed {
        logic start;
        logic ack;
    } t_temp_ctl;

    typedef struct packed {
        logic                     valid;
        logic signed [TEMP_W-1:0] temp;
        logic [SAMP_W-1:0]        samples;
    } t_temp_res;

    function automatic logic [SAMP_W-1:0] sat_samples(input logic [TALLY_W-1:0] cnt);
        if (int'(cnt) > SAMP_MAX) begin
            return SAMP_W'(SAMP_MAX);
        end
        return SAMP_W'(cnt);
    endfunction

endpackage

// ===== sv/iss_lane.sv =====
// One scaling lane: optional axis negation, multiply by coefficient, range shift, floor.
module iss_lane (
    input  logic                                i_clk,
    input  logic                                i_load,
    input  logic                                i_adv,
    input  logic signed [iss_pkg::RAW_W-1:0]    i_raw,
    input  logic                                i_neg,
    input  logic [iss_pkg::COEF_W-1:0]          i_coef,
    input  logic [iss_pkg::FS_W-1:0]            i_fs,
    output logic signed [iss_pkg::LANE_W-1:0]   o_res
);

    logic signed [iss_pkg::RAW_W-1:0]    w_v;
    logic signed [iss_pkg::L_PROD_W-1:0] r_prod;
    logic signed [iss_pkg::L_SH_W-1:0]   w_sh;
    logic signed [iss_pkg::LANE_W-1:0]   r_res;

    always_comb begin
        if (!i_neg) begin
            w_v = i_raw;
        end else if (i_raw == iss_pkg::RAW_MIN) begin
            w_v = iss_pkg::RAW_MAX;
        end else begin
            w_v = -i_raw;
        end
    end

    assign w_sh = iss_pkg::L_SH_W'(r_prod) <<< i_fs;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= w_v * $signed({1'b0, i_coef});
        end
        if (i_adv) begin
            r_res <= w_sh[iss_pkg::L_SH_W-1:iss_pkg::FRAC_SH];
        end
    end

    assign o_res = r_res;

endmodule

// ===== sv/iss_div.sv =====
// Iterative unsigned divider retiring four quotient bits per cycle.
module iss_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [iss_pkg::DVD_W-1:0]      i_dividend,
    input  logic [iss_pkg::TALLY_W-1:0]    i_divisor,
    output logic                           o_done,
    output logic [iss_pkg::DVD_W-1:0]      o_quot
);

    logic                              r_busy;
    logic                              r_done;
    logic [iss_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [iss_pkg::TALLY_W:0]         r_rem;
    logic [iss_pkg::TALLY_W-1:0]       r_dvs;
    logic [iss_pkg::DVD_W-1:0]         r_quo;
    logic [iss_pkg::TALLY_W:0]         n_rem;
    logic [iss_pkg::DVD_W-1:0]         n_quo;

    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int i = 0; i < iss_pkg::DIV_STEP_BITS; i++) begin
            n_rem = {n_rem[iss_pkg::TALLY_W-1:0], n_quo[iss_pkg::DVD_W-1]};
            n_quo = {n_quo[iss_pkg::DVD_W-2:0], 1'b0};
            if (n_rem >= {1'b0, r_dvs}) begin
                n_rem    = n_rem - {1'b0, r_dvs};
                n_quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == iss_pkg::DIV_CNT_W'(iss_pkg::DIV_ITERS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

// ===== sv/iss_temp_avg.sv =====
// Burst temperature accumulator and average with gain, offset and saturation.
module iss_temp_avg (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  iss_pkg::t_temp_ctl                   i_ctl,
    input  logic signed [iss_pkg::RAW_W-1:0]     i_temp_raw,
    input  logic                                 i_last,
    input  logic [iss_pkg::GAIN_W-1:0]           i_gain,
    input  logic signed [iss_pkg::OFFSET_W-1:0]  i_offset,
    output logic                                 o_done,
    output iss_pkg::t_temp_res                   o_res
);

    iss_pkg::t_tstate                      r_state;
    iss_pkg::t_tstate                      n_state;
    logic signed [iss_pkg::ACC_W-1:0]      r_accum;
    logic [iss_pkg::TALLY_W-1:0]           r_tally;
    logic [iss_pkg::TALLY_W-1:0]           r_cnt;
    logic                                  r_neg;
    logic [iss_pkg::DVD_W-1:0]             r_mag;
    logic signed [iss_pkg::QSH_W-1:0]      r_qsh;
    iss_pkg::t_temp_res                    r_res;

    logic signed [iss_pkg::T_PROD_W-1:0]   w_prod;
    logic [iss_pkg::T_PROD_W-1:0]          w_abs;
    logic                                  w_div_start;
    logic                                  w_div_done;
    logic [iss_pkg::DVD_W-1:0]             w_quot;
    logic signed [iss_pkg::DVD_W:0]        w_q;
    logic signed [iss_pkg::DEG_W-1:0]      w_deg;
    logic signed [iss_pkg::TEMP_W-1:0]     w_temp_sat;

    iss_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_mag),
        .i_divisor  (r_cnt),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign w_prod = r_accum * $signed({1'b0, i_gain});
    assign w_abs  = w_prod[iss_pkg::T_PROD_W-1] ? iss_pkg::T_PROD_W'(-w_prod)
                                                : iss_pkg::T_PROD_W'(w_prod);
    assign w_q    = r_neg ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
    assign w_deg  = iss_pkg::DEG_W'(r_qsh) + iss_pkg::DEG_W'(i_offset);

    always_comb begin
        if (w_deg > iss_pkg::DEG_W'(iss_pkg::TEMP_MAX)) begin
            w_temp_sat = iss_pkg::TEMP_W'(iss_pkg::TEMP_MAX);
        end else if (w_deg < iss_pkg::DEG_W'(iss_pkg::TEMP_MIN)) begin
            w_temp_sat = iss_pkg::TEMP_W'(iss_pkg::TEMP_MIN);
        end else begin
            w_temp_sat = iss_pkg::TEMP_W'(w_deg);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iss_pkg::TS_IDLE: begin
                if (i_ctl.start) begin
                    n_state = i_last ? iss_pkg::TS_MUL : iss_pkg::TS_DONE;
                end
            end
            iss_pkg::TS_MUL:   n_state = iss_pkg::TS_START;
            iss_pkg::TS_START: n_state = iss_pkg::TS_DIV;
            iss_pkg::TS_DIV: begin
                if (w_div_done) begin
                    n_state = iss_pkg::TS_NEG;
                end
            end
            iss_pkg::TS_NEG:   n_state = iss_pkg::TS_ADD;
            iss_pkg::TS_ADD:   n_state = iss_pkg::TS_DONE;
            iss_pkg::TS_DONE: begin
                if (i_ctl.ack) begin
                    n_state = iss_pkg::TS_IDLE;
                end
            end
            default:           n_state = iss_pkg::TS_IDLE;
        endcase
    end

    always_comb begin
        w_div_start = (r_state == iss_pkg::TS_START);
        o_done      = (r_state == iss_pkg::TS_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iss_pkg::TS_IDLE;
            r_accum <= '0;
            r_tally <= '0;
        end else begin
            r_state <= n_state;
            if (i_ctl.start && r_state == iss_pkg::TS_IDLE &&
                r_tally < iss_pkg::TALLY_W'(iss_pkg::MAX_BURST)) begin
                r_accum <= r_accum + iss_pkg::ACC_W'(i_temp_raw);
                r_tally <= r_tally + 1'b1;
            end else if (r_state == iss_pkg::TS_MUL) begin
                r_accum <= '0;
                r_tally <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start && r_state == iss_pkg::TS_IDLE) begin
            r_res <= '0;
        end
        if (r_state == iss_pkg::TS_MUL) begin
            r_neg <= w_prod[iss_pkg::T_PROD_W-1];
            r_mag <= iss_pkg::DVD_W'(w_abs);
            r_cnt <= r_tally;
        end
        if (r_state == iss_pkg::TS_NEG) begin
            r_qsh <= w_q[iss_pkg::DVD_W:iss_pkg::Q_SH];
        end
        if (r_state == iss_pkg::TS_ADD) begin
            r_res.valid   <= 1'b1;
            r_res.temp    <= w_temp_sat;
            r_res.samples <= iss_pkg::sat_samples(r_cnt);
        end
    end

    assign o_res = r_res;

endmodule

// ===== sv/imu_sample_scaler.sv =====
// IMU sample scaler top level: six scaling lanes, burst temperature average, merge stage.
//
// Input stream (s_axis): one transaction carries a raw 6-axis sample plus die
// temperature; tlast marks the last sample of a FIFO burst.
// Output stream (m_axis): one transaction per accepted sample with the scaled
// accelerometer (Q9.16) and gyro (Q12.16) axes, Y and Z negated. tuser is set on
// the burst-end sample, whose tdata also carries the burst average temperature
// (Q8.8) and the number of samples averaged; both are zero otherwise.
// Configuration: i_cfg_we writes register i_cfg_addr from i_cfg_data; write only
// while no sample is in flight.
// Pipeline: for an ordinary sample the lane product loads at the accepting edge,
// then the range-shift and merge registers follow. A burst-end sample also waits
// for the temperature gain multiply, a 12-step divider retiring 4 quotient bits
// per cycle, sign fix and offset add.
// Flow: one sample is in flight at a time. The output register holds a finished
// result while the next sample is taken in; if the receiver stalls, the merge waits
// and s_axis_tready stays low until the register frees up.
// Reset clears the burst sum and count, the handshakes, and restores the
// register defaults.
module imu_sample_scaler (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // accel_x, accel_y, accel_z, temp, gyro_x, gyro_y, gyro_z
    input  logic [iss_pkg::IN_W-1:0]           s_axis_tdata,
    input  logic                               s_axis_tvalid,
    input  logic                               s_axis_tlast,
    output logic                               s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temp_out, burst_samples
    output logic [iss_pkg::OUT_W-1:0]          m_axis_tdata,
    // temp_valid
    output logic                               m_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    input  logic                               i_cfg_we,
    input  logic [iss_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [iss_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    iss_pkg::t_state                         r_state;
    iss_pkg::t_state                         n_state;
    logic [iss_pkg::FS_W-1:0]                r_accel_fs;
    logic [iss_pkg::FS_W-1:0]                r_gyro_fs;
    logic [iss_pkg::COEF_W-1:0]              r_gravity;
    logic [iss_pkg::GAIN_W-1:0]              r_gain;
    logic signed [iss_pkg::OFFSET_W-1:0]     r_offset;

    logic                                    r_out_valid;
    logic [iss_pkg::OUT_W-1:0]               r_out_data;
    logic                                    r_out_user;

    logic                                    w_accept;
    logic                                    w_lane_adv;
    logic                                    w_out_free;
    logic                                    w_merge;
    logic                                    w_temp_done;
    iss_pkg::t_temp_ctl                      w_temp_ctl;
    iss_pkg::t_temp_res                      w_temp_res;
    logic signed [iss_pkg::LANE_W-1:0]       w_lane_res [iss_pkg::NUM_LANES];
    logic signed [iss_pkg::ACCEL_W-1:0]      w_accel [3];
    logic signed [iss_pkg::GYRO_W-1:0]       w_gyro [3];
    logic [iss_pkg::OUT_W-1:0]               w_tdata;

    genvar g;
    generate
        for (g = 0; g < iss_pkg::NUM_LANES; g++) begin : g_lane
            localparam int IS_ACCEL = (g < 3) ? 1 : 0;
            localparam int RAW_LSB  = (g < 3) ? g * iss_pkg::RAW_W
                                              : iss_pkg::GYRO_IN_LSB + (g - 3) * iss_pkg::RAW_W;
            iss_lane u_lane (
                .i_clk  (i_clk),
                .i_load (w_accept),
                .i_adv  (w_lane_adv),
                .i_raw  (s_axis_tdata[RAW_LSB +: iss_pkg::RAW_W]),
                .i_neg  ((g % 3) != 0),
                .i_coef (IS_ACCEL != 0 ? r_gravity : iss_pkg::GYRO_COEF),
                .i_fs   (IS_ACCEL != 0 ? r_accel_fs : r_gyro_fs),
                .o_res  (w_lane_res[g])
            );
        end
    endgenerate

    iss_temp_avg u_temp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_temp_ctl),
        .i_temp_raw (s_axis_tdata[iss_pkg::TEMP_IN_LSB +: iss_pkg::RAW_W]),
        .i_last     (s_axis_tlast),
        .i_gain     (r_gain),
        .i_offset   (r_offset),
        .o_done     (w_temp_done),
        .o_res      (w_temp_res)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (w_lane_res[k] > iss_pkg::LANE_W'(iss_pkg::ACCEL_MAX)) begin
                w_accel[k] = iss_pkg::ACCEL_W'(iss_pkg::ACCEL_MAX);
            end else if (w_lane_res[k] < iss_pkg::LANE_W'(iss_pkg::ACCEL_MIN)) begin
                w_accel[k] = iss_pkg::ACCEL_W'(iss_pkg::ACCEL_MIN);
            end else begin
                w_accel[k] = iss_pkg::ACCEL_W'(w_lane_res[k]);
            end
            w_gyro[k] = iss_pkg::GYRO_W'(w_lane_res[k + 3]);
        end
    end

    assign w_tdata = {{iss_pkg::OUT_PAD_W{1'b0}}, w_temp_res.samples, w_temp_res.temp,
                      w_gyro[2], w_gyro[1], w_gyro[0],
                      w_accel[2], w_accel[1], w_accel[0]};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iss_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = iss_pkg::ST_SCALE;
                end
            end
            iss_pkg::ST_SCALE: n_state = iss_pkg::ST_MERGE;
            iss_pkg::ST_MERGE: begin
                if (w_temp_done && w_out_free) begin
                    n_state = iss_pkg::ST_IDLE;
                end
            end
            default:           n_state = iss_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready    = (r_state == iss_pkg::ST_IDLE);
        w_accept         = s_axis_tvalid && s_axis_tready;
        w_lane_adv       = (r_state == iss_pkg::ST_SCALE);
        w_out_free       = !r_out_valid || m_axis_tready;
        w_merge          = (r_state == iss_pkg::ST_MERGE) && w_temp_done && w_out_free;
        w_temp_ctl.start = w_accept;
        w_temp_ctl.ack   = w_merge;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iss_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_merge) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_merge) begin
            r_out_data <= w_tdata;
            r_out_user <= w_temp_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_fs <= '0;
            r_gyro_fs  <= '0;
            r_gravity  <= iss_pkg::GRAVITY_RST;
            r_gain     <= iss_pkg::GAIN_RST;
            r_offset   <= iss_pkg::OFFSET_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                iss_pkg::CFG_ACCEL_FS:    r_accel_fs <= i_cfg_data[iss_pkg::FS_W-1:0];
                iss_pkg::CFG_GYRO_FS:     r_gyro_fs  <= i_cfg_data[iss_pkg::FS_W-1:0];
                iss_pkg::CFG_GRAVITY:     r_gravity  <= i_cfg_data[iss_pkg::COEF_W-1:0];
                iss_pkg::CFG_TEMP_GAIN:   r_gain     <= i_cfg_data[iss_pkg::GAIN_W-1:0];
                iss_pkg::CFG_TEMP_OFFSET: r_offset   <= i_cfg_data[iss_pkg::OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign m_axis_tvalid = r_out_valid;

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second sample taken while one is in flight");

    a_result_from_merge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(r_state) == iss_pkg::ST_MERGE)
        else $error("output valid raised outside the merge step");

    a_temp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |->
            m_axis_tdata[iss_pkg::TEMP_OUT_LSB +: iss_pkg::TEMP_W + iss_pkg::SAMP_W] == '0)
        else $error("temperature fields nonzero on a mid-burst transaction");

    a_samples_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |->
            m_axis_tdata[iss_pkg::SAMP_OUT_LSB +: iss_pkg::SAMP_W] != '0)
        else $error("burst average with zero samples");

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench of the IMU sample scaler: directed table, then random bursts.
`timescale 1ns / 100ps

module testbench;
    import iss_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_LO = CFG_ADDR_W'(5);
    localparam logic [CFG_ADDR_W-1:0] CFG_UNMAPPED_HI = CFG_ADDR_W'(2 ** CFG_ADDR_W - 1);
    localparam int NUM_PHASES = 6;
    localparam int PHASE_ITEMS = 225;

    typedef struct packed {
        logic                    last;
        logic signed [RAW_W-1:0] gyro_z;
        logic signed [RAW_W-1:0] gyro_y;
        logic signed [RAW_W-1:0] gyro_x;
        logic signed [RAW_W-1:0] temp;
        logic signed [RAW_W-1:0] accel_z;
        logic signed [RAW_W-1:0] accel_y;
        logic signed [RAW_W-1:0] accel_x;
    } t_imu_in;

    typedef struct packed {
        logic                      temp_valid;
        logic [OUT_PAD_W-1:0]      pad;
        logic [SAMP_W-1:0]         burst_samples;
        logic signed [TEMP_W-1:0]  temp_out;
        logic signed [GYRO_W-1:0]  gyro_z;
        logic signed [GYRO_W-1:0]  gyro_y;
        logic signed [GYRO_W-1:0]  gyro_x;
        logic signed [ACCEL_W-1:0] accel_z;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_x;
    } t_imu_out;

    typedef struct {
        bit                    cfg_we;
        logic [CFG_ADDR_W-1:0] cfg_addr;
        logic [CFG_DATA_W-1:0] cfg_data;
        bit                    has_item;
        t_imu_in               smp;
        bit                    typed;
        t_imu_out              want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  s_axis_tready;
    logic [OUT_W-1:0]      m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [FS_W-1:0]            cfg_accel_fs = '0;
    logic [FS_W-1:0]            cfg_gyro_fs = '0;
    logic [COEF_W-1:0]          cfg_gravity = GRAVITY_RST;
    logic [GAIN_W-1:0]          cfg_gain = GAIN_RST;
    logic signed [OFFSET_W-1:0] cfg_offset = OFFSET_RST;
    longint                     burst_sum = 0;
    int                         burst_len = 0;

    t_imu_out    awaited_q[$];
    t_dir_row    dir_rows[$];
    int          n_errors = 0;
    int          n_results = 0;
    bit          tx_idle_on = 1'b1;
    bit          rx_stall_on = 1'b1;
    int unsigned rx_hold = 0;
    t_imu_out    rx_got;
    t_imu_out    rx_want;

    imu_sample_scaler u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [RAW_W-1:0] rand_raw();
        case ($urandom_range(0, 14))
            0: return RAW_MIN;
            1: return RAW_MAX;
            2: return '0;
            3: return RAW_W'(1);
            4: return '1;
            default: return RAW_W'($urandom);
        endcase
    endfunction

    function automatic longint flip_axis(input longint r);
        return (r == longint'(RAW_MIN)) ? longint'(RAW_MAX) : -r;
    endfunction

    function automatic logic signed [ACCEL_W-1:0] accel_q16(input longint v);
        longint g;
        longint p;
        g = cfg_gravity;
        p = (v * g) <<< cfg_accel_fs;
        p = p >>> FRAC_SH;
        if (p > ACCEL_MAX) begin
            p = ACCEL_MAX;
        end else if (p < ACCEL_MIN) begin
            p = ACCEL_MIN;
        end
        return p[ACCEL_W-1:0];
    endfunction

    function automatic logic signed [GYRO_W-1:0] gyro_q16(input longint v);
        longint p;
        p = (v * 250 * 65536) <<< cfg_gyro_fs;
        p = p >>> 15;
        return p[GYRO_W-1:0];
    endfunction

    function automatic t_imu_out scale_sample(input t_imu_in s);
        t_imu_out r;
        longint   gain;
        longint   offs;
        longint   q;
        r = '0;
        r.accel_x = accel_q16(s.accel_x);
        r.accel_y = accel_q16(flip_axis(s.accel_y));
        r.accel_z = accel_q16(flip_axis(s.accel_z));
        r.gyro_x  = gyro_q16(s.gyro_x);
        r.gyro_y  = gyro_q16(flip_axis(s.gyro_y));
        r.gyro_z  = gyro_q16(flip_axis(s.gyro_z));
        if (burst_len < MAX_BURST) begin
            burst_sum = burst_sum + longint'(s.temp);
            burst_len = burst_len + 1;
        end
        if (s.last) begin
            gain = cfg_gain;
            offs = cfg_offset;
            q = (burst_sum * gain) / longint'(burst_len);
            q = (q >>> Q_SH) + offs;
            if (q > TEMP_MAX) begin
                q = TEMP_MAX;
            end else if (q < TEMP_MIN) begin
                q = TEMP_MIN;
            end
            r.temp_valid    = 1'b1;
            r.temp_out      = q[TEMP_W-1:0];
            r.burst_samples = (burst_len > SAMP_MAX) ? SAMP_W'(SAMP_MAX) : SAMP_W'(burst_len);
            burst_sum = 0;
            burst_len = 0;
        end
        return r;
    endfunction

    function automatic t_imu_in mk_in(input int ax, input int ay, input int az, input int t,
                                      input int gx, input int gy, input int gz, input bit last);
        t_imu_in s;
        s.accel_x = RAW_W'(ax);
        s.accel_y = RAW_W'(ay);
        s.accel_z = RAW_W'(az);
        s.temp    = RAW_W'(t);
        s.gyro_x  = RAW_W'(gx);
        s.gyro_y  = RAW_W'(gy);
        s.gyro_z  = RAW_W'(gz);
        s.last    = last;
        return s;
    endfunction

    function automatic t_imu_out mk_out(input int ax, input int ay, input int az, input int gx,
                                        input int gy, input int gz, input bit tv, input int t,
                                        input int n);
        t_imu_out r;
        r = '0;
        r.accel_x       = ACCEL_W'(ax);
        r.accel_y       = ACCEL_W'(ay);
        r.accel_z       = ACCEL_W'(az);
        r.gyro_x        = GYRO_W'(gx);
        r.gyro_y        = GYRO_W'(gy);
        r.gyro_z        = GYRO_W'(gz);
        r.temp_valid    = tv;
        r.temp_out      = TEMP_W'(t);
        r.burst_samples = SAMP_W'(n);
        return r;
    endfunction

    function automatic string fmt_out(input t_imu_out r);
        return $sformatf("ax=%0d ay=%0d az=%0d gx=%0d gy=%0d gz=%0d tv=%0b t=%0d n=%0d pad=%0b",
                         r.accel_x, r.accel_y, r.accel_z, r.gyro_x, r.gyro_y, r.gyro_z,
                         r.temp_valid, r.temp_out, r.burst_samples, r.pad);
    endfunction

    task automatic add_cfg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        t_dir_row row;
        row = '{cfg_we: 1'b1, cfg_addr: addr, cfg_data: data, has_item: 1'b0,
                smp: '0, typed: 1'b0, want: '0};
        dir_rows.push_back(row);
    endtask

    task automatic add_item(input t_imu_in smp, input bit typed, input t_imu_out want);
        t_dir_row row;
        row = '{cfg_we: 1'b0, cfg_addr: '0, cfg_data: '0, has_item: 1'b1,
                smp: smp, typed: typed, want: want};
        dir_rows.push_back(row);
    endtask

    // Hold off the input side until every sample in flight has come out.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        wait (awaited_q.size() == 0);
        @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_ACCEL_FS:    cfg_accel_fs = data[FS_W-1:0];
            CFG_GYRO_FS:     cfg_gyro_fs  = data[FS_W-1:0];
            CFG_GRAVITY:     cfg_gravity  = data[COEF_W-1:0];
            CFG_TEMP_GAIN:   cfg_gain     = data[GAIN_W-1:0];
            CFG_TEMP_OFFSET: cfg_offset   = data[OFFSET_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic push_sample(input t_imu_in smp, input bit typed, input t_imu_out want);
        t_imu_out pred;
        int       gap;
        pred = scale_sample(smp);
        awaited_q.push_back(typed ? want : pred);
        gap = tx_idle_on ? idle_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        {s_axis_tlast, s_axis_tdata} <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            rx_got = {m_axis_tuser, m_axis_tdata};
            if (awaited_q.size() == 0) begin
                if (n_errors < 10) begin
                    $display("unexpected result %0d: %s", n_results, fmt_out(rx_got));
                end
                n_errors++;
            end else begin
                rx_want = awaited_q.pop_front();
                if (rx_got !== rx_want) begin
                    if (n_errors < 10) begin
                        $display("mismatch on result %0d\n  expected %s\n  actual   %s",
                                 n_results, fmt_out(rx_want), fmt_out(rx_got));
                    end
                    n_errors++;
                end
            end
            n_results++;
        end
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_stall_on && $urandom_range(0, 3) == 0) begin
            rx_hold <= idle_len();
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        #4_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        int       phase;
        int       sent;
        int       len;
        int       long_len;
        bit       long_done;
        t_imu_in  smp;
        logic [FS_W-1:0]            fs_a;
        logic [FS_W-1:0]            fs_g;
        logic [COEF_W-1:0]          grav;
        logic [GAIN_W-1:0]          gain;
        logic signed [OFFSET_W-1:0] offs;

        add_item(mk_in(0, 0, 0, 0, 0, 0, 0, 1), 1, mk_out(0, 0, 0, 0, 0, 0, 1, 6400, 1));
        add_item(mk_in(0, 0, 0, 0, 1, 0, 0, 0), 1, mk_out(0, 0, 0, 500, 0, 0, 0, 0, 0));
        add_item(mk_in(-32768, 0, 0, 0, 0, 0, 0, 1), 1,
                 mk_out(-1285378, 0, 0, 0, 0, 0, 1, 6400, 2));
        add_item(mk_in(32767, 32767, 32767, 32767, 32767, 32767, 32767, 0), 0, '0);
        add_item(mk_in(-32768, -32768, -32768, -32768, -32768, -32768, -32768, 0), 0, '0);
        add_item(mk_in(1234, -1, 1, -300, -1234, 32767, -32768, 1), 0, '0);
        // accelerometer saturation at full gravity and 16g
        add_cfg(CFG_GRAVITY, 24'hFFFFFF);
        add_cfg(CFG_ACCEL_FS, CFG_DATA_W'(3));
        add_item(mk_in(32767, -32768, 32767, 0, 0, 0, 0, 1), 1,
                 mk_out(ACCEL_MAX, ACCEL_MAX, ACCEL_MIN, 0, 0, 0, 1, 6400, 1));
        add_item(mk_in(-32768, 1, -32768, 5, 32767, -32768, 1, 0), 0, '0);
        add_cfg(CFG_GYRO_FS, CFG_DATA_W'(3));
        add_item(mk_in(7, -7, 0, -5, 32767, -32768, 32767, 1), 0, '0);
        // temperature saturation both ways
        add_cfg(CFG_TEMP_GAIN, 24'hFFFFFF);
        add_cfg(CFG_TEMP_OFFSET, 24'h007FFF);
        add_item(mk_in(0, 0, 0, 32767, 0, 0, 0, 1), 1,
                 mk_out(0, 0, 0, 0, 0, 0, 1, TEMP_MAX, 1));
        add_cfg(CFG_TEMP_OFFSET, 24'h008000);
        add_item(mk_in(0, 0, 0, -32768, 0, 0, 0, 1), 1,
                 mk_out(0, 0, 0, 0, 0, 0, 1, TEMP_MIN, 1));
        add_cfg(CFG_TEMP_GAIN, '0);
        add_cfg(CFG_TEMP_OFFSET, '0);
        add_item(mk_in(0, 0, 0, 12345, 0, 0, 0, 1), 1, mk_out(0, 0, 0, 0, 0, 0, 1, 0, 1));
        // write to an unmapped index must leave every register alone
        add_cfg(CFG_UNMAPPED_LO, 24'hFFFFFF);
        add_item(mk_in(100, -100, 200, -20000, 300, -300, 1, 0), 0, '0);
        add_item(mk_in(-5, 5, -9, 20000, -3, 3, -1, 1), 0, '0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].cfg_we) begin
                drain();
                set_reg(dir_rows[i].cfg_addr, dir_rows[i].cfg_data);
            end
            if (dir_rows[i].has_item) begin
                push_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: begin
                    fs_a = '0; fs_g = '0; grav = GRAVITY_RST; gain = GAIN_RST; offs = OFFSET_RST;
                end
                1: begin
                    fs_a = '1; fs_g = '1; grav = '1; gain = '1; offs = TEMP_W'(TEMP_MIN);
                end
                2: begin
                    fs_a = FS_W'(1); fs_g = FS_W'(2); grav = COEF_W'($urandom);
                    gain = GAIN_W'($urandom); offs = OFFSET_W'($urandom);
                end
                3: begin
                    fs_a = '0; fs_g = '1; grav = '0; gain = '0; offs = TEMP_W'(TEMP_MAX);
                end
                default: begin
                    fs_a = FS_W'($urandom); fs_g = FS_W'($urandom);
                    grav = COEF_W'($urandom); gain = GAIN_W'($urandom_range(0, 262143));
                    offs = OFFSET_W'($urandom);
                end
            endcase
            drain();
            set_reg(CFG_ACCEL_FS, CFG_DATA_W'(fs_a));
            set_reg(CFG_GYRO_FS, CFG_DATA_W'(fs_g));
            set_reg(CFG_GRAVITY, CFG_DATA_W'(grav));
            set_reg(CFG_TEMP_GAIN, CFG_DATA_W'(gain));
            set_reg(CFG_TEMP_OFFSET, CFG_DATA_W'(offs));
            set_reg(CFG_ADDR_W'($urandom_range(CFG_UNMAPPED_LO, CFG_UNMAPPED_HI)),
                    CFG_DATA_W'($urandom));

            tx_idle_on  = (phase % 3) != 2;
            rx_stall_on = (phase != 2) && (phase != 4);
            // one burst in phases 1, 3 and 5 at or past the averaging limit
            case (phase)
                1: long_len = MAX_BURST + 7;
                3: long_len = MAX_BURST;
                5: long_len = MAX_BURST + 1;
                default: long_len = 0;
            endcase
            long_done = 1'b0;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (long_len > 0 && !long_done) begin
                    len = long_len;
                    long_done = 1'b1;
                end else if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(20, 60);
                end else begin
                    len = $urandom_range(1, 12);
                end
                for (int k = 0; k < len; k++) begin
                    smp = mk_in(rand_raw(), rand_raw(), rand_raw(), rand_raw(),
                                rand_raw(), rand_raw(), rand_raw(), k == len - 1);
                    push_sample(smp, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/iss_pkg.sv
sv/iss_lane.sv
sv/iss_div.sv
sv/iss_temp_avg.sv
sv/imu_sample_scaler.sv
tb/testbench.sv
